/* rtl/core/unix_seconds_to_calendar_core_assert.svh */
// Assertion macros for the calendar conversion core.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message string.
`ifndef UNIX_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define UNIX_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define USC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define USC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define USC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define USC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/usc_pkg.sv */
package usc_pkg;

    typedef struct packed {
        logic [31:0] unix_seconds;
    } stamp_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_YEAR,
        ST_MONTH,
        ST_WRITE
    } state_t;

    // Which time-of-day field the shared divide step is producing.
    typedef enum logic [1:0] {
        FIELD_SEC,
        FIELD_MIN,
        FIELD_HOUR
    } field_t;

    typedef struct packed {
        logic   load;
        logic   mul;
        logic   split;
        field_t field;
        logic   year_step;
        logic   month_step;
        logic   write;
    } cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } status_t;

    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400 = 9'd370;

    // x / 60 = (x * RECIP_60) >> SHIFT_60, exact for every 32-bit x.
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam int unsigned SHIFT_60 = 37;
    // x / 24 = ((x >> 3) * RECIP_3) >> SHIFT_3, exact for every 32-bit x.
    localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
    localparam int unsigned SHIFT_3  = 33;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_NOV = 4'd10;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // Length of a month counted from zero.
    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/core/usc_stream_if.sv */
interface usc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/unix_seconds_to_calendar_core.sv */
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// UTC calendar date and time (year, month, day, hour, minute, second).
// The stamp channel takes one input word; the calendar channel gives one
// result word for it. Both use valid/ready and move a word at a clock edge
// where both are high.
// The work runs one item at a time: time-of-day division through one shared
// reciprocal multiplier, then the elapsed years and then the elapsed months
// are subtracted from the day count, one at a time. A new word is taken the
// cycle after the result is registered.
// The result sits in an output register, so the next word is accepted while
// an earlier result still waits. If the receiver stalls and the next result
// is ready too, the block holds in its final step until the register frees.
// Reset clears the controller and the output valid; the datapath registers
// are not reset, and no clearing pass is needed.
`include "unix_seconds_to_calendar_core_assert.svh"

module unix_seconds_to_calendar_core (
    input  logic         clk,
    input  logic         rst_n,
    usc_stream_if.sink   stamp,
    usc_stream_if.source calendar
);
    import usc_pkg::*;

    cmd_t      cmd;
    status_t   status;
    calendar_t result;
    logic      stamp_ready;
    logic      result_valid;

    // The controller sequences the division, year and month steps and owns
    // both handshakes.
    usc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .stamp_valid  (stamp.valid),
        .stamp_ready  (stamp_ready),
        .result_valid (result_valid),
        .result_ready (calendar.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the working value, the split fields, the year and
    // month counters and the output register.
    usc_datapath u_datapath (
        .clk    (clk),
        .stamp  (stamp.data),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    assign stamp.ready    = stamp_ready;
    assign calendar.valid = result_valid;
    assign calendar.data  = result;

    // Once a word is taken the block is busy with it.
    `USC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, stamp.valid && stamp.ready, !stamp.ready, "ready returned right after an accepted word")

    // Month and day always count from one and stay in range.
    `USC_ASSERT_IMP(a_date_range, clk, rst_n, calendar.valid, (calendar.data.month >= 4'd1) && (calendar.data.month <= 4'd12) && (calendar.data.day >= 5'd1), "month or day out of range")

    // The time-of-day remainders stay below their divisors.
    `USC_ASSERT_IMP(a_time_range, clk, rst_n, calendar.valid, (calendar.data.hour < 5'd24) && (calendar.data.minute < 6'd60) && (calendar.data.second < 6'd60), "time of day out of range")

    // A 32-bit count never reaches past 2106.
    `USC_ASSERT_IMP(a_year_range, clk, rst_n, calendar.valid, (calendar.data.year >= 12'd1970) && (calendar.data.year <= 12'd2106), "year out of range")

endmodule

/* rtl/core/usc_ctrl.sv */
module usc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stamp_valid,
    output logic             stamp_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  usc_pkg::status_t status,
    output usc_pkg::cmd_t    cmd
);
    import usc_pkg::*;

    state_t state_reg, state_next;
    field_t phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= FIELD_SEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.field      = phase_reg;
        stamp_ready    = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                stamp_ready = 1'b1;
                if (stamp_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = FIELD_SEC;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                cmd.split = 1'b1;
                unique case (phase_reg)
                    FIELD_SEC:
                    begin
                        phase_next = FIELD_MIN;
                        state_next = ST_MUL;
                    end
                    FIELD_MIN:
                    begin
                        phase_next = FIELD_HOUR;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        state_next = ST_YEAR;
                    end
                endcase
            end
            ST_YEAR:
            begin
                if (status.year_fit)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                if (status.month_fit)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

/* rtl/core/usc_datapath.sv */
module usc_datapath (
    input  logic               clk,
    input  usc_pkg::stamp_t    stamp,
    input  usc_pkg::cmd_t      cmd,
    output usc_pkg::status_t   status,
    output usc_pkg::calendar_t result
);
    import usc_pkg::*;

    logic [31:0] work_reg, work_next;
    logic [63:0] prod_reg, prod_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [15:0] day_reg, day_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  y4_reg, y4_next;
    logic [6:0]  y100_reg, y100_next;
    logic [8:0]  y400_reg, y400_next;
    logic [3:0]  mon_reg, mon_next;
    calendar_t   result_reg, result_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] quot;
    logic [31:0] prod_back;
    logic [5:0]  rem;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;

    // Gregorian rule from the running remainders of the year.
    assign leap     = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = month_length(mon_reg, leap);

    assign status.year_fit  = day_reg < {7'd0, year_len};
    assign status.month_fit = (mon_reg == MONTH_DEC) || (day_reg < {11'd0, mon_len});

    // Shared divide step: a multiply by the reciprocal, then the quotient
    // and remainder are taken from the registered product in the next cycle.
    always_comb begin
        unique case (cmd.field)
            FIELD_HOUR:
            begin
                mul_a = {3'd0, work_reg[31:3]};
                mul_b = RECIP_3;
            end
            default:
            begin
                mul_a = work_reg;
                mul_b = RECIP_60;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.field)
            FIELD_HOUR:
            begin
                quot      = {1'b0, prod_reg[63:SHIFT_3]};
                prod_back = (quot << 4) + (quot << 3);
            end
            default:
            begin
                quot      = {5'd0, prod_reg[63:SHIFT_60]};
                prod_back = (quot << 6) - (quot << 2);
            end
        endcase
    end

    // The remainder is below 64, so the low bits of the difference suffice.
    assign rem = work_reg[5:0] - prod_back[5:0];

    always_comb begin
        work_next   = work_reg;
        prod_next   = prod_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        y4_next     = y4_reg;
        y100_next   = y100_reg;
        y400_next   = y400_reg;
        mon_next    = mon_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            work_next = stamp.unix_seconds;
            year_next = EPOCH_YEAR;
            y4_next   = EPOCH_MOD4;
            y100_next = EPOCH_MOD100;
            y400_next = EPOCH_MOD400;
            mon_next  = 4'd0;
        end

        if (cmd.mul)
        begin
            prod_next = mul_a * mul_b;
        end

        if (cmd.split)
        begin
            work_next = quot;
            unique case (cmd.field)
                FIELD_SEC:  sec_next = rem;
                FIELD_MIN:  min_next = rem;
                default:
                begin
                    hour_next = rem[4:0];
                    day_next  = quot[15:0];
                end
            endcase
        end

        if (cmd.year_step)
        begin
            day_next  = day_reg - {7'd0, year_len};
            year_next = year_reg + 12'd1;
            y4_next   = y4_reg + 2'd1;
            y100_next = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
            y400_next = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
        end

        if (cmd.month_step)
        begin
            day_next = day_reg - {11'd0, mon_len};
            mon_next = mon_reg + 4'd1;
        end

        if (cmd.write)
        begin
            result_next.year   = year_reg;
            result_next.month  = mon_reg + 4'd1;
            result_next.day    = day_reg[4:0] + 5'd1;
            result_next.hour   = hour_reg;
            result_next.minute = min_reg;
            result_next.second = sec_reg;
        end
    end

    always_ff @(posedge clk) begin
        work_reg   <= work_next;
        prod_reg   <= prod_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        day_reg    <= day_next;
        year_reg   <= year_next;
        y4_reg     <= y4_next;
        y100_reg   <= y100_next;
        y400_reg   <= y400_next;
        mon_reg    <= mon_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
